// ----- src/zst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zst_pkg
// Shared types and constants of the zero-sum triplet finder.
// ----------------------------------------------------------------------------
package zst_pkg;

   // fixed width of the sample and result value ports
   localparam int SAMPLE_BITS = 16;

   // depth of the candidate queue between search and collect
   localparam int FIFO_DEPTH = 4;

   typedef enum logic [5:0] {
      F_LOAD  = 6'b000001,
      F_ROW_A = 6'b000010,
      F_ROW_B = 6'b000100,
      F_STEP  = 6'b001000,
      F_SKIP  = 6'b010000,
      F_END   = 6'b100000
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_SCAN = 3'b010,
      B_EMIT = 3'b100
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage : zst_pkg
`default_nettype wire

// ----- src/zst_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module zst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule : zst_ram
`default_nettype wire

// ----- src/zst_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zst_fifo
// Short register queue carrying candidate triples and end-of-run markers.
// ----------------------------------------------------------------------------
module zst_fifo #(
   parameter int WIDTH = 49
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [WIDTH-1:0]      push_data,
   input  wire logic                  pop,
   output logic      [WIDTH-1:0]      pop_data,
   output zst_pkg::fifo_status_type   status
);

   localparam int PW = $clog2(zst_pkg::FIFO_DEPTH);

   logic [WIDTH-1:0] mem_ff [zst_pkg::FIFO_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (PW+1)'(zst_pkg::FIFO_DEPTH));
   assign status.empty = (count_ff == '0);

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("zst_fifo: push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("zst_fifo: pop while empty");
`endif

endmodule : zst_fifo
`default_nettype wire

// ----- src/zst_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zst_search
// Front end: loads the value set, then walks the two-pointer search and
// queues every zero-sum hit, followed by an end-of-run marker.
// ----------------------------------------------------------------------------
module zst_search #(
   parameter int MAX_VALUES = 64,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [zst_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                  req_final_item,
   output logic                                       push,
   output logic      [3*VALUE_BITS:0]                 push_data,
   input  wire zst_pkg::fifo_status_type              status
);

   localparam int VAW = $clog2(MAX_VALUES);
   localparam int VCW = $clog2(MAX_VALUES + 1);
   localparam int SW  = VALUE_BITS + 2;

   zst_pkg::front_state_type state_ff, state_in;
   logic [VCW-1:0]        count_ff, count_in;
   logic [VAW-1:0]        i_ff, i_in;
   logic [VAW-1:0]        j_ff, j_in;
   logic [VAW-1:0]        k_ff, k_in;
   logic [VALUE_BITS-1:0] vi_ff, vi_in;
   logic [VALUE_BITS-1:0] hit_ff, hit_in;

   logic                  accept;
   logic                  wr_en;
   logic [VALUE_BITS-1:0] wr_value;
   logic [VALUE_BITS-1:0] vj, vk;
   logic [SW-1:0]         sum;

   assign busy     = (state_ff != zst_pkg::F_LOAD);
   assign accept   = start && !busy;
   assign wr_en    = accept && (count_ff < VCW'(MAX_VALUES));
   assign wr_value = VALUE_BITS'($unsigned(req_sample));

   // both copies hold the same set; one follows j, the other k
   zst_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_VALUES)) u_ram_j (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[VAW-1:0]),
      .wr_data (wr_value),
      .rd_addr (j_in),
      .rd_data (vj)
   );

   zst_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_VALUES)) u_ram_k (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[VAW-1:0]),
      .wr_data (wr_value),
      .rd_addr (k_in),
      .rd_data (vk)
   );

   assign sum = {{2{vi_ff[VALUE_BITS-1]}}, vi_ff}
              + {{2{vj[VALUE_BITS-1]}}, vj}
              + {{2{vk[VALUE_BITS-1]}}, vk};

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      vi_in     = vi_ff;
      hit_in    = hit_ff;
      push      = 1'b0;
      push_data = {1'b0, vi_ff, vj, vk};
      case (state_ff)
         zst_pkg::F_LOAD: begin
            if (accept) begin
               if (wr_en) begin
                  count_in = count_ff + VCW'(1);
               end
               if (req_final_item) begin
                  i_in = '0;
                  if (count_in < VCW'(3)) begin
                     state_in = zst_pkg::F_END;
                  end else begin
                     state_in = zst_pkg::F_ROW_A;
                  end
               end
            end
         end
         zst_pkg::F_ROW_A: begin
            // fetch the first value through the j copy
            j_in     = i_ff;
            k_in     = VAW'(count_ff - VCW'(1));
            state_in = zst_pkg::F_ROW_B;
         end
         zst_pkg::F_ROW_B: begin
            vi_in    = vj;
            j_in     = i_ff + VAW'(1);
            state_in = zst_pkg::F_STEP;
         end
         zst_pkg::F_STEP: begin
            if (j_ff >= k_ff) begin
               if (VCW'(i_ff) == count_ff - VCW'(3)) begin
                  state_in = zst_pkg::F_END;
               end else begin
                  i_in     = i_ff + VAW'(1);
                  state_in = zst_pkg::F_ROW_A;
               end
            end else if (sum == '0) begin
               if (!status.full) begin
                  push     = 1'b1;
                  hit_in   = vj;
                  j_in     = j_ff + VAW'(1);
                  state_in = zst_pkg::F_SKIP;
               end
            end else if (sum[SW-1]) begin
               j_in = j_ff + VAW'(1);
            end else begin
               k_in = k_ff - VAW'(1);
            end
         end
         zst_pkg::F_SKIP: begin
            // step j past the run of values equal to the hit
            if (j_ff < k_ff && vj == hit_ff) begin
               j_in = j_ff + VAW'(1);
            end else begin
               state_in = zst_pkg::F_STEP;
            end
         end
         zst_pkg::F_END: begin
            push_data = {1'b1, {(3*VALUE_BITS){1'b0}}};
            if (!status.full) begin
               push     = 1'b1;
               count_in = '0;
               state_in = zst_pkg::F_LOAD;
            end
         end
         default: begin
            state_in = zst_pkg::F_LOAD;
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zst_pkg::F_LOAD;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      k_ff   <= k_in;
      vi_ff  <= vi_in;
      hit_ff <= hit_in;
   end

`ifndef SYNTHESIS
   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == zst_pkg::F_STEP || state_ff == zst_pkg::F_SKIP) |-> (j_ff <= k_ff))
      else $error("zst_search: middle pointer passed last pointer");
`endif

endmodule : zst_search
`default_nettype wire

// ----- src/zst_collect.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zst_collect
// Back end: drops repeated triples against the triple store, flags overflow
// and emits the kept triples of a run one per cycle.
// ----------------------------------------------------------------------------
module zst_collect #(
   parameter int MAX_TRIPLES = 64,
   parameter int VALUE_BITS  = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   output logic                                    pop,
   input  wire logic [3*VALUE_BITS:0]              pop_data,
   input  wire zst_pkg::fifo_status_type           status,
   output logic                                    rsp_strobe,
   output logic signed [zst_pkg::SAMPLE_BITS-1:0]  rsp_first_value,
   output logic signed [zst_pkg::SAMPLE_BITS-1:0]  rsp_second_value,
   output logic signed [zst_pkg::SAMPLE_BITS-1:0]  rsp_third_value,
   output logic                                    rsp_triple_valid,
   output logic                                    rsp_store_overflow,
   output logic                                    rsp_final_result
);

   localparam int TIW = (MAX_TRIPLES > 1) ? $clog2(MAX_TRIPLES) : 1;
   localparam int TCW = $clog2(MAX_TRIPLES + 1);
   localparam int TW  = 3 * VALUE_BITS;
   localparam int OW  = zst_pkg::SAMPLE_BITS;

   zst_pkg::back_state_type state_ff, state_in;
   logic [TCW-1:0] tcount_ff, tcount_in;
   logic [TCW-1:0] t_ff, t_in;
   logic           ovf_ff, ovf_in;
   logic [TW-1:0]  cand_ff, cand_in;

   logic           strobe_ff, strobe_in;
   logic [OW-1:0]  first_ff, first_in;
   logic [OW-1:0]  second_ff, second_in;
   logic [OW-1:0]  third_ff, third_in;
   logic           valid_ff, valid_in;
   logic           oflag_ff, oflag_in;
   logic           last_ff, last_in;

   logic           wr_en;
   logic [TW-1:0]  rd_word;

   zst_ram #(.WIDTH(TW), .DEPTH(MAX_TRIPLES)) u_ram_triple (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tcount_ff[TIW-1:0]),
      .wr_data (cand_ff),
      .rd_addr (t_in[TIW-1:0]),
      .rd_data (rd_word)
   );

   always_comb begin
      state_in  = state_ff;
      tcount_in = tcount_ff;
      t_in      = t_ff;
      ovf_in    = ovf_ff;
      cand_in   = cand_ff;
      pop       = 1'b0;
      wr_en     = 1'b0;
      strobe_in = 1'b0;
      first_in  = OW'(rd_word[3*VALUE_BITS-1:2*VALUE_BITS]);
      second_in = OW'(rd_word[2*VALUE_BITS-1:VALUE_BITS]);
      third_in  = OW'(rd_word[VALUE_BITS-1:0]);
      valid_in  = 1'b1;
      oflag_in  = ovf_ff;
      last_in   = (t_ff + TCW'(1) == tcount_ff);
      case (state_ff)
         zst_pkg::B_IDLE: begin
            // read address parks at entry 0 so a scan or emit starts at once
            t_in = '0;
            if (!status.empty) begin
               pop = 1'b1;
               if (pop_data[TW]) begin
                  if (tcount_ff == '0) begin
                     strobe_in = 1'b1;
                     first_in  = '0;
                     second_in = '0;
                     third_in  = '0;
                     valid_in  = 1'b0;
                     last_in   = 1'b1;
                     ovf_in    = 1'b0;
                  end else begin
                     state_in = zst_pkg::B_EMIT;
                  end
               end else begin
                  cand_in  = pop_data[TW-1:0];
                  state_in = zst_pkg::B_SCAN;
               end
            end
         end
         zst_pkg::B_SCAN: begin
            if (t_ff == tcount_ff) begin
               if (tcount_ff == TCW'(MAX_TRIPLES)) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en     = 1'b1;
                  tcount_in = tcount_ff + TCW'(1);
               end
               t_in     = '0;
               state_in = zst_pkg::B_IDLE;
            end else if (rd_word == cand_ff) begin
               t_in     = '0;
               state_in = zst_pkg::B_IDLE;
            end else begin
               t_in = t_ff + TCW'(1);
            end
         end
         zst_pkg::B_EMIT: begin
            strobe_in = 1'b1;
            if (last_in) begin
               tcount_in = '0;
               ovf_in    = 1'b0;
               t_in      = '0;
               state_in  = zst_pkg::B_IDLE;
            end else begin
               t_in = t_ff + TCW'(1);
            end
         end
         default: begin
            state_in  = zst_pkg::B_IDLE;
            tcount_in = '0;
            ovf_in    = 1'b0;
            t_in      = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= zst_pkg::B_IDLE;
         tcount_ff <= '0;
         ovf_ff    <= 1'b0;
         t_ff      <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         tcount_ff <= tcount_in;
         ovf_ff    <= ovf_in;
         t_ff      <= t_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff   <= cand_in;
      first_ff  <= first_in;
      second_ff <= second_in;
      third_ff  <= third_in;
      valid_ff  <= valid_in;
      oflag_ff  <= oflag_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_first_value    = $signed(first_ff);
   assign rsp_second_value   = $signed(second_ff);
   assign rsp_third_value    = $signed(third_ff);
   assign rsp_triple_valid   = valid_ff;
   assign rsp_store_overflow = oflag_ff;
   assign rsp_final_result   = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      tcount_ff <= TCW'(MAX_TRIPLES))
      else $error("zst_collect: triple count past store depth");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (strobe_ff && last_ff) |-> (tcount_ff == '0 && !ovf_ff))
      else $error("zst_collect: run state not cleared after last result");
`endif

endmodule : zst_collect
`default_nettype wire

// ----- src/zero_sum_triplet_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zero_sum_triplet_finder
// Finds the distinct zero-sum triples of a sorted value set with a
// two-pointer search and reports them in discovery order.
// ----------------------------------------------------------------------------
// Values load one word per cycle while busy is low; the word with
// req_final_item set closes the set and raises busy for the search. The
// search walks one pointer step per cycle over the value store, after the
// setup states F_ROW_A and F_ROW_B for each first index, unless a full
// queue holds it on a hit. Each hit is queued to the back end, which checks
// it against the kept triples at one entry per cycle and stalls the search
// only when its short queue fills. Results leave one per cycle on
// rsp_strobe and cannot be held off. Busy drops when the search ends, so
// the next set may load while the previous results drain.
// ----------------------------------------------------------------------------
module zero_sum_triplet_finder #(
   parameter int MAX_VALUES  = 64,
   parameter int MAX_TRIPLES = 64,
   parameter int VALUE_BITS  = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic signed [zst_pkg::SAMPLE_BITS-1:0]  req_sample,
   input  wire logic                                    req_final_item,
   output logic                                         rsp_strobe,
   output logic signed [zst_pkg::SAMPLE_BITS-1:0]       rsp_first_value,
   output logic signed [zst_pkg::SAMPLE_BITS-1:0]       rsp_second_value,
   output logic signed [zst_pkg::SAMPLE_BITS-1:0]       rsp_third_value,
   output logic                                         rsp_triple_valid,
   output logic                                         rsp_store_overflow,
   output logic                                         rsp_final_result
);

   localparam int QW = 3 * VALUE_BITS + 1;

   logic                     push;
   logic [QW-1:0]            push_data;
   logic                     pop;
   logic [QW-1:0]            pop_data;
   zst_pkg::fifo_status_type status;

   zst_search #(
      .MAX_VALUES (MAX_VALUES),
      .VALUE_BITS (VALUE_BITS)
   ) u_search (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_sample     (req_sample),
      .req_final_item (req_final_item),
      .push           (push),
      .push_data      (push_data),
      .status         (status)
   );

   zst_fifo #(
      .WIDTH (QW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   zst_collect #(
      .MAX_TRIPLES (MAX_TRIPLES),
      .VALUE_BITS  (VALUE_BITS)
   ) u_collect (
      .clock              (clock),
      .reset              (reset),
      .pop                (pop),
      .pop_data           (pop_data),
      .status             (status),
      .rsp_strobe         (rsp_strobe),
      .rsp_first_value    (rsp_first_value),
      .rsp_second_value   (rsp_second_value),
      .rsp_third_value    (rsp_third_value),
      .rsp_triple_valid   (rsp_triple_valid),
      .rsp_store_overflow (rsp_store_overflow),
      .rsp_final_result   (rsp_final_result)
   );

endmodule : zero_sum_triplet_finder
`default_nettype wire
